// ===== sv/expression_lexer_unit_macros.svh =====
// Assertion macros used by the expression lexer result queue.
`ifndef EXPRESSION_LEXER_UNIT_MACROS_SVH
`define EXPRESSION_LEXER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define ELX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define ELX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ELX_ASSERT(lbl, prop, msg)
`define ELX_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/elx_pkg.sv =====
// Types, constants and character classes of the expression lexer.
package elx_pkg;

  localparam int MAX_TEXT = 65536;
  localparam int Q_DEPTH  = 4;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;
  localparam logic [2:0]  KW_FULL   = 3'd6;
  localparam logic [2:0]  KW_DEAD   = 3'd7;

  typedef enum logic [2:0] {
    TK_NUMBER  = 3'd0,
    TK_NAME    = 3'd1,
    TK_KEYWORD = 3'd2,
    TK_PUNCT   = 3'd3,
    TK_END     = 3'd4,
    TK_ERROR   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  punct;
    logic [15:0] start;
    logic [15:0] len;
    logic [30:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return (b >= 8'h61) && (b <= 8'h7A);
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_digit(b) || is_lower(b) || ((b >= 8'h41) && (b <= 8'h5A)) || (b == 8'h5F);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b == 8'h21) || (b == 8'h3E) || (b == 8'h3C) || (b == 8'h2B) ||
           (b == 8'h2D) || (b == 8'h2A) || (b == 8'h28) || (b == 8'h29) ||
           (b == 8'h2F) || (b == 8'h3D) || (b == 8'h3B);
  endfunction

  // characters of "return"
  function automatic logic [7:0] kw_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h6E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] kw_track(input logic [2:0] prog, input logic [7:0] b);
    return ((prog < KW_FULL) && (b == kw_char(prog))) ? prog + 3'd1 : KW_DEAD;
  endfunction

endpackage

// ===== sv/elx_core.sv =====
// Scanner state and per-byte token decision.
module elx_core
  import elx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] text_byte,
  output push_t      push
);

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_NUM   = 2'd1,
    M_IDENT = 2'd2,
    M_ERR   = 2'd3
  } mode_t;

  localparam logic [16:0] WRAP = (MAX_TEXT >= 65536) ? 17'h10000 : 17'(MAX_TEXT);

  mode_t       mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] start_r, start_nxt;
  logic [15:0] len_r, len_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [2:0]  kw_r, kw_nxt;

  logic [15:0] pos_adv;
  logic [15:0] len_inc;
  logic [3:0]  digit;
  logic [34:0] acc_mul;
  res_t        close_res, char_res;
  logic        close_v, char_v;

  always_comb begin
    pos_adv = (({1'b0, pos_r} + 17'd1) == WRAP) ? 16'd0 : pos_r + 16'd1;
    len_inc = (len_r < LEN_MAX) ? len_r + 16'd1 : len_r;
    digit   = 4'(text_byte - 8'h30);
    acc_mul = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + 35'(digit);
  end

  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    kw_nxt    = kw_r;
    close_v   = 1'b0;
    char_v    = 1'b0;
    close_res = '0;
    char_res  = '0;
    case (mode_r)
      M_ERR: begin
        if (text_byte == 8'h00) begin
          mode_nxt  = M_IDLE;
          pos_nxt   = '0;
          start_nxt = '0;
          len_nxt   = '0;
          acc_nxt   = '0;
          kw_nxt    = '0;
        end else begin
          pos_nxt = pos_adv;
        end
      end
      default: begin
        if ((mode_r == M_NUM) && is_digit(text_byte)) begin
          acc_nxt = (acc_mul > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc_mul[30:0];
          len_nxt = len_inc;
          pos_nxt = pos_adv;
        end else if ((mode_r == M_IDENT) && is_lower(text_byte)) begin
          kw_nxt  = kw_track(kw_r, text_byte);
          len_nxt = len_inc;
          pos_nxt = pos_adv;
        end else begin
          if (mode_r == M_NUM) begin
            close_v         = 1'b1;
            close_res.kind  = TK_NUMBER;
            close_res.start = start_r;
            close_res.len   = len_r;
            close_res.value = acc_r;
          end else if (mode_r == M_IDENT) begin
            close_v         = 1'b1;
            close_res.kind  = ((kw_r == KW_FULL) && !is_word(text_byte)) ? TK_KEYWORD : TK_NAME;
            close_res.start = start_r;
            close_res.len   = len_r;
          end
          mode_nxt = M_IDLE;
          if (text_byte == 8'h00) begin
            char_v         = 1'b1;
            char_res.kind  = TK_END;
            char_res.start = pos_r;
            pos_nxt        = '0;
            start_nxt      = '0;
            len_nxt        = '0;
            acc_nxt        = '0;
            kw_nxt         = '0;
          end else begin
            if (is_space(text_byte)) begin
              char_v = 1'b0;
            end else if (is_punct(text_byte)) begin
              char_v         = 1'b1;
              char_res.kind  = TK_PUNCT;
              char_res.punct = text_byte;
              char_res.start = pos_r;
              char_res.len   = 16'd1;
            end else if (is_digit(text_byte)) begin
              mode_nxt  = M_NUM;
              start_nxt = pos_r;
              len_nxt   = 16'd1;
              acc_nxt   = 31'(digit);
            end else if (is_lower(text_byte)) begin
              mode_nxt  = M_IDENT;
              start_nxt = pos_r;
              len_nxt   = 16'd1;
              kw_nxt    = kw_track(3'd0, text_byte);
            end else begin
              char_v         = 1'b1;
              char_res.kind  = TK_ERROR;
              char_res.punct = text_byte;
              char_res.start = pos_r;
              char_res.len   = 16'd1;
              mode_nxt       = M_ERR;
            end
            pos_nxt = pos_adv;
          end
        end
      end
    endcase
    close_res.last = !char_v;
    char_res.last  = 1'b1;
  end

  always_comb begin
    push.cnt    = fire ? {close_v & char_v, close_v ^ char_v} : 2'd0;
    push.first  = close_v ? close_res : char_res;
    push.second = char_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      acc_r   <= '0;
      kw_r    <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

// ===== sv/elx_outq.sv =====
// Result queue: takes up to two tokens a cycle, hands out one.
`include "expression_lexer_unit_macros.svh"

module elx_outq
  import elx_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  res_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               pop;

  always_comb begin
    out_valid = (cnt_r != '0);
    out_res   = mem_r[rd_r];
    pop       = out_valid && out_ready;
    room      = ((cnt_r - Q_CNT_W'(pop)) <= Q_CNT_W'(Q_DEPTH - 2));
    cnt_nxt   = cnt_r + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_r + Q_PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + Q_PTR_W'(push.cnt);
      rd_r  <= rd_r + Q_PTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  `ELX_ASSERT(a_no_overflow, (int'(cnt_r) + int'(push.cnt) - int'(pop)) <= Q_DEPTH, "queue overflow")
  `ELX_ASSERT(a_pair_last, (push.cnt == 2'd2) |-> (!push.first.last && push.second.last), "bad last flags on token pair")
  `ELX_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (cnt_r == '0), "queue not empty after reset")

endmodule

// ===== sv/expression_lexer_unit.sv =====
// Expression lexer top level: input register, scanner, result queue.
// An accepted byte waits in the input register until the result queue has room; its tokens are then queued.
// Throughput: one byte per cycle while the result queue has room; a byte that closes a run and emits a
// second token puts two tokens onto the single output port, absorbed by a four-entry result queue.
// Reset: synchronous active-low rst_n clears scanner state, offsets and the queue.
module expression_lexer_unit
  import elx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [7:0] punct_char, [23:8] start_pos, [39:24] token_length,
                                  // [70:40] number_value, [71] zero
  output logic [2:0]  out_tuser,  // [2:0] token_kind
  output logic        out_tlast   // last_of_run
);

  logic [7:0] byte_r;
  logic       valid_r;
  logic       room;
  logic       fire;
  push_t      push;
  res_t       res;

  assign fire      = valid_r && room;
  assign in_tready = !valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  elx_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .text_byte (byte_r),
    .push      (push)
  );

  elx_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {1'b0, res.value, res.len, res.start, res.punct};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== tb/tb.sv =====
// Testbench for expression_lexer_unit: byte stream in, token stream checked against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import elx_pkg::*;

  localparam int    HOLD_CYCLES  = 300;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    RANDOM_BYTES = 400;
  localparam string OPERATORS    = "!><+-*()/=;";
  localparam string KEYWORD      = "return";

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD,
    SCAN_JUNK
  } scan_mode_t;

  typedef struct {
    kind_t       kind;
    logic [7:0]  ch;
    logic [15:0] start;
    logic [15:0] len;
    logic [30:0] value;
    logic        last;
  } token_t;

  class lexer_scoreboard;
    scan_mode_t  mode;
    logic [15:0] offset;
    logic [15:0] run_at;
    logic [15:0] run_len;
    logic [30:0] acc;
    logic [2:0]  kw_hits;
    token_t      due[$];
    int          fails;
    int          live_bytes;

    function new();
      fails = 0;
      live_bytes = 0;
      restart();
    endfunction

    function void restart();
      mode = SCAN_IDLE;
      offset = '0;
      run_at = '0;
      run_len = '0;
      acc = '0;
      kw_hits = '0;
    endfunction

    function bit digit_char(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit lower_char(logic [7:0] b);
      return b >= "a" && b <= "z";
    endfunction

    function bit word_char(logic [7:0] b);
      return digit_char(b) || lower_char(b) || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function bit blank_char(logic [7:0] b);
      return (b >= 8'd9 && b <= 8'd13) || b == " ";
    endfunction

    function bit op_char(logic [7:0] b);
      for (int i = 0; i < OPERATORS.len(); i++)
        if (OPERATORS[i] == b) return 1'b1;
      return 1'b0;
    endfunction

    function void kw_step(logic [7:0] b);
      if (kw_hits < KW_FULL && b == KEYWORD[kw_hits]) kw_hits++;
      else kw_hits = KW_DEAD;
    endfunction

    function void add(kind_t k, logic [7:0] c, logic [15:0] s, logic [15:0] l,
                      logic [30:0] v);
      token_t t;
      t.kind = k;
      t.ch = c;
      t.start = s;
      t.len = l;
      t.value = v;
      t.last = 1'b0;
      due.push_back(t);
    endfunction

    // one accepted text byte; queues the tokens it closes or produces
    function void note_byte(logic [7:0] b);
      logic [15:0] here;
      int          queued;
      longint      wide;
      here = offset;
      queued = due.size();
      if (mode == SCAN_JUNK) begin
        if (b == 8'd0) restart();
        else offset++;
        return;
      end
      live_bytes++;
      if (mode == SCAN_NUMBER && digit_char(b)) begin
        wide = longint'(acc) * 10 + longint'(b) - 48;
        acc = (wide > longint'(VALUE_MAX)) ? VALUE_MAX : wide[30:0];
        if (run_len != LEN_MAX) run_len++;
        offset++;
        return;
      end
      if (mode == SCAN_WORD && lower_char(b)) begin
        kw_step(b);
        if (run_len != LEN_MAX) run_len++;
        offset++;
        return;
      end
      if (mode == SCAN_NUMBER) begin
        add(TK_NUMBER, 8'd0, run_at, run_len, acc);
      end else if (mode == SCAN_WORD) begin
        add((kw_hits == KW_FULL && !word_char(b)) ? TK_KEYWORD : TK_NAME,
            8'd0, run_at, run_len, '0);
      end
      mode = SCAN_IDLE;
      if (b == 8'd0) begin
        add(TK_END, 8'd0, here, 16'd0, '0);
        restart();
      end else begin
        if (blank_char(b)) begin
        end else if (op_char(b)) begin
          add(TK_PUNCT, b, here, 16'd1, '0);
        end else if (digit_char(b)) begin
          mode = SCAN_NUMBER;
          run_at = here;
          run_len = 16'd1;
          acc = 31'(b - 8'h30);
        end else if (lower_char(b)) begin
          mode = SCAN_WORD;
          run_at = here;
          run_len = 16'd1;
          kw_hits = '0;
          kw_step(b);
        end else begin
          add(TK_ERROR, b, here, 16'd1, '0);
          mode = SCAN_JUNK;
        end
        offset++;
      end
      if (due.size() > queued) due[due.size() - 1].last = 1'b1;
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [71:0] data, logic last);
      token_t t;
      if (due.size() == 0) begin
        $error("unexpected token: kind %0d tdata %h", kind, data);
        fails++;
        return;
      end
      t = due.pop_front();
      compare("token_kind", t.kind, kind);
      compare("punct_char", t.ch, data[7:0]);
      compare("start_pos", t.start, data[23:8]);
      compare("token_length", t.len, data[39:24]);
      compare("number_value", t.value, data[70:40]);
      compare("tdata pad", 64'd0, data[71]);
      compare("last_of_run", t.last, last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  lexer_scoreboard sb;
  bit hold_req;
  bit steady;
  int burst_left;
  int stalled;

  expression_lexer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // transaction monitor and stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stalled = 0;
      else stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: changing stall styles, plus one long hold-off on request
  initial begin
    int style;
    int span;
    out_tready = 1'b0;
    style = 0;
    span = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        if (span == 0) begin
          style = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (style)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ~out_tready;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(0, 24);
      end
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed text with random content, some broken keywords and junk bytes
  task automatic send_random_text();
    int tokens;
    int pick;
    int n;
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
        repeat (n) send_byte(8'($urandom_range(8'h30, 8'h39)));
      end else if (pick < 45) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(8'h61, 8'h7A)));
      end else if (pick < 55) begin
        send_text(KEYWORD);
        case ($urandom_range(0, 5))
          0: send_byte(" ");
          1: send_byte(OPERATORS[$urandom_range(0, 10)]);
          2: send_byte("_");
          3: send_byte(8'($urandom_range(8'h30, 8'h39)));
          4: send_byte(8'($urandom_range(8'h41, 8'h5A)));
          default: ;
        endcase
      end else if (pick < 58) begin
        send_text(KEYWORD.substr(0, $urandom_range(0, 4)));
      end else if (pick < 80) begin
        send_byte(OPERATORS[$urandom_range(0, 10)]);
      end else if (pick < 96) begin
        send_byte(($urandom_range(0, 5) == 5) ? 8'd32 : 8'($urandom_range(9, 13)));
      end else begin
        send_byte(8'($urandom_range(1, 255)));
      end
    end
    if ($urandom_range(0, 9) != 0) send_byte(8'd0);
  endtask

  initial begin
    int base;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    hold_req = 1'b0;
    steady = 1'b0;
    burst_left = 0;
    stalled = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // every operator, every blank, keyword closed by end of text, junk then ignored text
    send_text(OPERATORS);
    for (int c = 9; c <= 13; c++) send_byte(8'(c));
    send_byte(" ");
    send_text(KEYWORD);
    send_byte(8'd0);
    send_byte(8'hFF);
    send_text("q");
    send_byte(8'd0);
    drain();

    // receiver holds off while the sender keeps pushing
    steady = 1'b1;
    hold_req = 1'b1;
    repeat (48) send_byte(OPERATORS[$urandom_range(0, 10)]);
    steady = 1'b0;
    drain();

    // back-to-back identifier, number and punctuation
    steady = 1'b1;
    send_text("abcd 123;x ");
    send_byte(8'd0);
    steady = 1'b0;

    base = sb.live_bytes;
    while (sb.live_bytes - base < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 3) == 0);
      send_random_text();
      if ($urandom_range(0, 15) == 0) drain();
    end
    steady = 1'b0;
    send_byte(8'd0);
    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== expression_lexer_unit.f =====
+incdir+sv
sv/elx_pkg.sv
sv/elx_core.sv
sv/elx_outq.sv
sv/expression_lexer_unit.sv
tb/tb.sv
